// File: design/lzss_stream_decompressor_defines.svh
// Assertion macros for the LZSS stream decompressor.
`ifndef LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LZSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lzss assertion failed");

// Next-cycle implication, disabled during reset.
`define LZSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lzss assertion failed");

`endif

// File: design/lzss_pkg.sv
// Shared types and constants of the LZSS stream decompressor.
package lzss_pkg;

   localparam int DEF_HISTORY_DEPTH = 8192;
   localparam int DEF_MIN_MATCH     = 3;

   localparam int DIST_W      = 13;
   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 32;
   localparam int RSP_DATA_W  = 48;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = '1;
   localparam logic [3:0]         FLAG_NEED   = 4'd8;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_DIST  = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ADDLEN,
      S_CHKLIM,
      S_READ,
      S_COPY,
      S_LIT,
      S_END,
      S_ERR
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] a;
      logic [COUNT_W-1:0] b;
      logic               sub;
   } alu_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] sum;
      logic               cout;
   } alu_rsp_type;

   typedef struct packed {
      logic               valid;
      logic [BYTE_W-1:0]  data;
      logic               is_data;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } emit_type;

endpackage

// File: design/lzss_alu.sv
// Shared 32-bit add/subtract unit with carry out.
module lzss_alu (
   input  lzss_pkg::alu_req_type req,
   output lzss_pkg::alu_rsp_type rsp
);

   logic [lzss_pkg::COUNT_W:0] res;

   assign res = {1'b0, req.a}
              + {1'b0, req.b ^ {lzss_pkg::COUNT_W{req.sub}}}
              + (lzss_pkg::COUNT_W+1)'(req.sub);

   assign rsp.sum  = res[lzss_pkg::COUNT_W-1:0];
   assign rsp.cout = res[lzss_pkg::COUNT_W];

endmodule

// File: design/lzss_hist.sv
// History ring memory: one write port, one registered read port.
module lzss_hist #(
   parameter  int HISTORY_DEPTH = lzss_pkg::DEF_HISTORY_DEPTH,
   localparam int AddrW         = $clog2(HISTORY_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AddrW-1:0]            wr_addr,
   input  logic [lzss_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [AddrW-1:0]            rd_addr,
   output logic [lzss_pkg::BYTE_W-1:0] rd_data
);

   logic [lzss_pkg::BYTE_W-1:0] mem [HISTORY_DEPTH];
   logic [lzss_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lzss_seq.sv
// Sequencer: decodes flag, literal and token bytes and drives the shared unit.
module lzss_seq #(
   parameter  int HISTORY_DEPTH = lzss_pkg::DEF_HISTORY_DEPTH,
   parameter  int MIN_MATCH     = lzss_pkg::DEF_MIN_MATCH,
   localparam int AddrW         = $clog2(HISTORY_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lzss_pkg::BYTE_W-1:0]  req_byte,
   input  logic                         req_last,
   input  logic [lzss_pkg::COUNT_W-1:0] limit,
   input  logic                         out_free,
   output lzss_pkg::emit_type           emit,
   output lzss_pkg::alu_req_type        alu_req,
   input  lzss_pkg::alu_rsp_type        alu_rsp,
   output logic                         mem_wr_en,
   output logic [AddrW-1:0]             mem_wr_addr,
   output logic [lzss_pkg::BYTE_W-1:0]  mem_wr_data,
   output logic                         mem_rd_en,
   output logic [AddrW-1:0]             mem_rd_addr,
   input  logic [lzss_pkg::BYTE_W-1:0]  mem_rd_data
);

   localparam int LenW  = $clog2(7 + MIN_MATCH + 1);
   localparam int DistW = lzss_pkg::DIST_W + 1;
   localparam int PtrW  = ((AddrW > DistW) ? AddrW : DistW) + 1;

   lzss_pkg::state_type          state_ff, state_in;
   logic [lzss_pkg::BYTE_W-1:0]  byte_ff, byte_in;
   logic                         last_ff, last_in;
   logic [lzss_pkg::BYTE_W-1:0]  flag_ff, flag_in;
   logic [3:0]                   bitpos_ff, bitpos_in;
   logic                         phase_ff, phase_in;
   logic [lzss_pkg::BYTE_W-1:0]  low_ff, low_in;
   logic                         disc_ff, disc_in;
   logic [lzss_pkg::COUNT_W-1:0] produced_ff, produced_in;
   logic [AddrW-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [AddrW-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [LenW-1:0]              len_ff, len_in;
   logic [lzss_pkg::COUNT_W-1:0] sum_ff, sum_in;
   logic                         sum_hi_ff, sum_hi_in;
   lzss_pkg::status_type         err_ff, err_in;

   logic [DistW-1:0] tok_dist;
   logic [LenW-1:0]  tok_len;
   logic [PtrW-1:0]  back;
   logic [PtrW-1:0]  start;
   logic             flag_bit;
   logic [AddrW-1:0] wr_ptr_next;
   logic [AddrW-1:0] rd_ptr_next;

   assign tok_dist = {1'b0, byte_ff[7:3], low_ff} + DistW'(1);
   assign tok_len  = LenW'(byte_ff[2:0]) + LenW'(MIN_MATCH);
   assign back     = PtrW'(wr_ptr_ff) - PtrW'(tok_dist);
   assign start    = back[PtrW-1] ? back + PtrW'(HISTORY_DEPTH) : back;
   assign flag_bit = flag_ff[bitpos_ff[2:0]];

   assign wr_ptr_next = (wr_ptr_ff == AddrW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == AddrW'(HISTORY_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzss_pkg::S_IDLE: begin
            if (req_valid) state_in = lzss_pkg::S_DECODE;
         end
         lzss_pkg::S_DECODE: begin
            if (disc_ff) begin
               state_in = lzss_pkg::S_IDLE;
            end else if (bitpos_ff[3]) begin
               state_in = lzss_pkg::S_END;
            end else if (!flag_bit) begin
               state_in = alu_rsp.cout ? lzss_pkg::S_ERR : lzss_pkg::S_LIT;
            end else if (!phase_ff) begin
               state_in = lzss_pkg::S_END;
            end else begin
               state_in = alu_rsp.cout ? lzss_pkg::S_ADDLEN : lzss_pkg::S_ERR;
            end
         end
         lzss_pkg::S_ADDLEN: state_in = lzss_pkg::S_CHKLIM;
         lzss_pkg::S_CHKLIM: begin
            state_in = (sum_hi_ff || !alu_rsp.cout) ? lzss_pkg::S_ERR : lzss_pkg::S_READ;
         end
         lzss_pkg::S_READ: state_in = lzss_pkg::S_COPY;
         lzss_pkg::S_COPY: begin
            if (out_free) begin
               state_in = (len_ff == LenW'(1)) ? lzss_pkg::S_END : lzss_pkg::S_READ;
            end
         end
         lzss_pkg::S_LIT: begin
            if (out_free) state_in = lzss_pkg::S_END;
         end
         lzss_pkg::S_END: begin
            if (!last_ff || out_free) state_in = lzss_pkg::S_IDLE;
         end
         lzss_pkg::S_ERR: begin
            if (out_free) state_in = lzss_pkg::S_IDLE;
         end
         default: state_in = lzss_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      byte_in     = byte_ff;
      last_in     = last_ff;
      flag_in     = flag_ff;
      bitpos_in   = bitpos_ff;
      phase_in    = phase_ff;
      low_in      = low_ff;
      disc_in     = disc_ff;
      produced_in = produced_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      sum_hi_in   = sum_hi_ff;
      err_in      = err_ff;
      req_ready   = 1'b0;
      alu_req     = '0;
      emit        = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = wr_ptr_ff;
      mem_wr_data = byte_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = rd_ptr_ff;

      case (state_ff)
         lzss_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               byte_in = req_byte;
               last_in = req_last;
            end
         end
         lzss_pkg::S_DECODE: begin
            if (disc_ff) begin
               if (last_ff) begin
                  produced_in = '0;
                  wr_ptr_in   = '0;
                  flag_in     = '0;
                  bitpos_in   = lzss_pkg::FLAG_NEED;
                  phase_in    = 1'b0;
                  low_in      = '0;
                  disc_in     = 1'b0;
               end
            end else if (bitpos_ff[3]) begin
               flag_in   = byte_ff;
               bitpos_in = '0;
            end else if (!flag_bit) begin
               alu_req.a   = produced_ff;
               alu_req.b   = limit;
               alu_req.sub = 1'b1;
               err_in      = lzss_pkg::ST_OVER;
            end else if (!phase_ff) begin
               low_in   = byte_ff;
               phase_in = 1'b1;
            end else begin
               alu_req.a   = produced_ff;
               alu_req.b   = lzss_pkg::COUNT_W'(tok_dist);
               alu_req.sub = 1'b1;
               phase_in    = 1'b0;
               err_in      = lzss_pkg::ST_DIST;
               len_in      = tok_len;
               rd_ptr_in   = AddrW'(start);
            end
         end
         lzss_pkg::S_ADDLEN: begin
            alu_req.a   = produced_ff;
            alu_req.b   = lzss_pkg::COUNT_W'(len_ff);
            alu_req.sub = 1'b0;
            sum_in      = alu_rsp.sum;
            sum_hi_in   = alu_rsp.cout;
         end
         lzss_pkg::S_CHKLIM: begin
            alu_req.a   = limit;
            alu_req.b   = sum_ff;
            alu_req.sub = 1'b1;
            err_in      = lzss_pkg::ST_OVER;
            if (!sum_hi_ff && alu_rsp.cout) begin
               bitpos_in = bitpos_ff + 4'd1;
            end
         end
         lzss_pkg::S_READ: begin
            mem_rd_en = 1'b1;
            rd_ptr_in = rd_ptr_next;
         end
         lzss_pkg::S_COPY: begin
            alu_req.a   = produced_ff;
            alu_req.b   = lzss_pkg::COUNT_W'(1);
            alu_req.sub = 1'b0;
            mem_wr_data = mem_rd_data;
            if (out_free) begin
               emit.valid   = 1'b1;
               emit.data    = mem_rd_data;
               emit.is_data = 1'b1;
               emit.status  = lzss_pkg::ST_OK;
               mem_wr_en    = 1'b1;
               produced_in  = alu_rsp.sum;
               wr_ptr_in    = wr_ptr_next;
               len_in       = len_ff - LenW'(1);
            end
         end
         lzss_pkg::S_LIT: begin
            alu_req.a   = produced_ff;
            alu_req.b   = lzss_pkg::COUNT_W'(1);
            alu_req.sub = 1'b0;
            if (out_free) begin
               emit.valid   = 1'b1;
               emit.data    = byte_ff;
               emit.is_data = 1'b1;
               emit.status  = lzss_pkg::ST_OK;
               mem_wr_en    = 1'b1;
               produced_in  = alu_rsp.sum;
               wr_ptr_in    = wr_ptr_next;
               bitpos_in    = bitpos_ff + 4'd1;
            end
         end
         lzss_pkg::S_END: begin
            if (last_ff && out_free) begin
               emit.valid  = 1'b1;
               emit.status = phase_ff ? lzss_pkg::ST_TRUNC : lzss_pkg::ST_OK;
               emit.count  = produced_ff;
               produced_in = '0;
               wr_ptr_in   = '0;
               flag_in     = '0;
               bitpos_in   = lzss_pkg::FLAG_NEED;
               phase_in    = 1'b0;
               low_in      = '0;
               disc_in     = 1'b0;
            end
         end
         lzss_pkg::S_ERR: begin
            if (out_free) begin
               emit.valid  = 1'b1;
               emit.status = err_ff;
               emit.count  = produced_ff;
               if (last_ff) begin
                  produced_in = '0;
                  wr_ptr_in   = '0;
                  flag_in     = '0;
                  bitpos_in   = lzss_pkg::FLAG_NEED;
                  phase_in    = 1'b0;
                  low_in      = '0;
                  disc_in     = 1'b0;
               end else begin
                  disc_in = 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lzss_pkg::S_IDLE;
         flag_ff     <= '0;
         bitpos_ff   <= lzss_pkg::FLAG_NEED;
         phase_ff    <= 1'b0;
         low_ff      <= '0;
         disc_ff     <= 1'b0;
         produced_ff <= '0;
         wr_ptr_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         flag_ff     <= flag_in;
         bitpos_ff   <= bitpos_in;
         phase_ff    <= phase_in;
         low_ff      <= low_in;
         disc_ff     <= disc_in;
         produced_ff <= produced_in;
         wr_ptr_ff   <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      rd_ptr_ff <= rd_ptr_in;
      len_ff    <= len_in;
      sum_ff    <= sum_in;
      sum_hi_ff <= sum_hi_in;
      err_ff    <= err_in;
   end

endmodule

// File: design/lzss_stream_decompressor.sv
// Top level of the LZSS stream decompressor.
//
// req_* takes one compressed byte per word; req_tlast marks the final byte of
// a stream. rsp_* returns one word per decompressed byte (tuser = 1) and one
// summary word per stream (tuser = 0, tlast = 1) carrying status and count.
// csr_* writes the output limit; write it only while the block is idle.
// Each input word takes its own pass through the sequencer, req_tready is
// high only between passes:
//   flag byte or first token byte: decode, then end
//   literal: decode with a limit check, output, then end
//   token second byte: distance check, length add, limit check, then read and copy per byte
//   a word ending the stream adds its summary within the same pass.
// The shared 32-bit add/subtract unit serves all count and limit checks; the
// history memory is read and then written once per copied byte, so each copied
// byte passes through a read state and then a copy state.
// A one-word output register sits on rsp_*; when the receiver stalls, the
// sequencer holds in its emitting state until that register frees up.
// Reset clears the stream state and sets the limit to all ones; the history
// memory is not cleared and needs no sweep.
`include "lzss_stream_decompressor_defines.svh"

module lzss_stream_decompressor #(
   parameter int HISTORY_DEPTH = lzss_pkg::DEF_HISTORY_DEPTH,
   parameter int MIN_MATCH     = lzss_pkg::DEF_MIN_MATCH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // in_byte
   input  logic                            req_tlast,  // in_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lzss_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_byte, status, byte_count
   output logic                            rsp_tlast,  // out_last
   output logic [0:0]                      rsp_tuser,  // is_data
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lzss_pkg::COUNT_W-1:0]    csr_data
);

   localparam int AddrW = $clog2(HISTORY_DEPTH);

   logic [lzss_pkg::COUNT_W-1:0] limit_ff;
   logic                         rsp_valid_ff;
   logic [lzss_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                         rsp_isdata_ff;
   lzss_pkg::status_type         rsp_status_ff;
   logic [lzss_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                        out_free;
   lzss_pkg::emit_type          emit;
   lzss_pkg::alu_req_type       alu_req;
   lzss_pkg::alu_rsp_type       alu_rsp;
   logic                        mem_wr_en;
   logic [AddrW-1:0]            mem_wr_addr;
   logic [lzss_pkg::BYTE_W-1:0] mem_wr_data;
   logic                        mem_rd_en;
   logic [AddrW-1:0]            mem_rd_addr;
   logic [lzss_pkg::BYTE_W-1:0] mem_rd_data;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   lzss_seq #(
      .HISTORY_DEPTH(HISTORY_DEPTH),
      .MIN_MATCH    (MIN_MATCH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_byte   (req_tdata),
      .req_last   (req_tlast),
      .limit      (limit_ff),
      .out_free   (out_free),
      .emit       (emit),
      .alu_req    (alu_req),
      .alu_rsp    (alu_rsp),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   lzss_alu u_alu (
      .req(alu_req),
      .rsp(alu_rsp)
   );

   lzss_hist #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_hist (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= lzss_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (emit.valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_byte_ff   <= emit.data;
         rsp_isdata_ff <= emit.is_data;
         rsp_status_ff <= emit.status;
         rsp_count_ff  <= emit.count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_count_ff, rsp_status_ff, rsp_byte_ff};
   assign rsp_tlast  = !rsp_isdata_ff;
   assign rsp_tuser  = rsp_isdata_ff;

   `LZSS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `LZSS_ASSERT_IMPL(a_emit_needs_room, clock, reset, emit.valid, out_free)
   `LZSS_ASSERT_IMPL(a_summary_zero_byte, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[7:0] == '0)

endmodule
